/* rtl/eltlr_pkg.sv */
// Shared types, constants and the loop matcher for the exclusive-loop rewriter.
package eltlr_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned NWords  = 5;
	localparam int unsigned MaxOut  = 4;
	localparam int unsigned CntW    = 3;
	localparam int unsigned ConsW   = 5;
	localparam int unsigned IdxW    = 1;

	localparam logic [IdxW-1:0] RegBaseBias = 1'd0;
	localparam logic [IdxW-1:0] RegStolen   = 1'd1;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		word_t [NWords-1:0] words;
	} window_t;

	typedef struct packed {
		word_t                    replacement_word;
		logic                     word_valid;
		logic                     touches_memory;
		logic [ConsW-1:0]         bytes_consumed;
		logic                     last_of_run;
	} result_t;

	// Classified window: up to four words ready to emit.
	typedef struct packed {
		word_t [MaxOut-1:0]       wrd;
		logic  [MaxOut-1:0]       mem;
		logic  [CntW-1:0]         cnt;
		logic  [ConsW-1:0]        cons;
	} plan_t;

	typedef struct packed {
		logic base_bias;
		logic [WordW-1:0] stolen;
	} cfg_t;

	function automatic logic [4:0] fld(input word_t w, input int unsigned sh);
		fld = w[sh +: 5];
	endfunction

	function automatic logic is_stx(input word_t w, input logic [1:0] sz, input logic [4:0] xn);
		is_stx = ((w & 32'h3F400000) == 32'h08000000) && (w[31:30] == sz) &&
			(w[14:10] == 5'd31) && (w[9:5] == xn);
	endfunction

	function automatic logic is_cbnz(input word_t w, input logic [4:0] ws,
			input logic [18:0] off);
		is_cbnz = (w[31:24] == 8'h35) && (w[4:0] == ws) && (w[23:5] == off);
	endfunction

	function automatic plan_t classify(input window_t win, input cfg_t cfg);
		plan_t p;
		word_t i0, i1, i2, i3, i4;
		logic [1:0] sz;
		logic [4:0] wt, xn, ws, wv, ws2, n, m, wm, wexp, wnew;
		logic d64, hit, wmv;
		word_t szb, szd, lse;
		logic [2:0] op;
		logic [11:0] imm;
		p = '0;
		i0 = win.words[0]; i1 = win.words[1]; i2 = win.words[2];
		i3 = win.words[3]; i4 = win.words[4];
		sz = i0[31:30];
		d64 = (sz == 2'd3);
		wt = i0[4:0];
		xn = i0[9:5];
		szb = d64 ? 32'h40000000 : 32'h0;
		szd = d64 ? 32'h80000000 : 32'h0;
		hit = 1'b0;
		op = 3'd7;
		wm = '0;
		wmv = 1'b0;
		ws = '0;
		if ((i0 & 32'h3F400000) == 32'h08400000 && sz[1] && i0[20:16] == 5'd31 &&
				i0[14:10] == 5'd31) begin
			// swap
			ws = i1[20:16];
			wv = i1[4:0];
			if (is_stx(i1, sz, xn) && is_cbnz(i2, ws, 19'h7FFFE) &&
					(cfg.base_bias || cfg.stolen[wt] || cfg.stolen[xn] ||
					cfg.stolen[ws] || cfg.stolen[wv])) begin
				hit = 1'b1;
				p.wrd[0] = 32'hB8E08000 | szb | {11'd0, wv, 6'd0, xn, wt};
				p.mem[0] = 1'b1;
				p.cnt = 3'd1;
				if (ws != 5'd31) begin
					p.wrd[1] = 32'h2A1F03E0 | {27'd0, ws};
					p.cnt = 3'd2;
				end
				p.cons = 5'd12;
			end
			// register op
			if (!hit) begin
				unique case (i1 & 32'hFFE0FC00)
					(d64 ? 32'h8B000000 : 32'h0B000000): op = 3'd0;
					(d64 ? 32'hAA000000 : 32'h2A000000): op = 3'd1;
					(d64 ? 32'hCA000000 : 32'h4A000000): op = 3'd2;
					(d64 ? 32'h8A000000 : 32'h0A000000): op = 3'd3;
					(d64 ? 32'hCB000000 : 32'h4B000000): op = 3'd4;
					default: op = 3'd7;
				endcase
				ws2 = i1[4:0]; n = i1[9:5]; m = i1[20:16];
				if (n == wt) begin
					wm = m; wmv = 1'b1;
				end else if (op != 3'd4 && m == wt) begin
					wm = n; wmv = 1'b1;
				end
				ws = i2[20:16];
				if (op != 3'd7 && wmv && is_stx(i2, sz, xn) && i2[4:0] == ws2 &&
						is_cbnz(i3, ws, 19'h7FFFD)) begin
					hit = 1'b1;
					if (!(op >= 3'd3 && wm == ws)) begin
						p.cons = 5'd16;
						if (op <= 3'd2) begin
							lse = op == 3'd0 ? 32'hB8E00000 :
								op == 3'd1 ? 32'hB8E03000 : 32'hB8E02000;
							p.wrd[0] = lse | szb | {11'd0, wm, 6'd0, xn, wt};
							p.mem[0] = 1'b1;
							p.wrd[1] = i1;
							p.cnt = 3'd2;
						end else begin
							p.wrd[0] = (op == 3'd3 ? 32'h2A200000 : 32'h4B000000) | szd |
								{11'd0, wm, 6'd0, 5'd31, ws};
							p.wrd[1] = (op == 3'd3 ? 32'hB8E01000 : 32'hB8E00000) | szb |
								{11'd0, ws, 6'd0, xn, wt};
							p.mem[1] = 1'b1;
							p.wrd[2] = i1;
							p.cnt = 3'd3;
						end
						if (ws != 5'd31) begin
							p.wrd[p.cnt[1:0]] = 32'h2A1F03E0 | {27'd0, ws};
							p.cnt = p.cnt + 3'd1;
						end
					end
				end
			end
			// add immediate
			if (!hit && (i1 & 32'hFFC00000) == (d64 ? 32'h91000000 : 32'h11000000) &&
					i1[9:5] == wt) begin
				ws2 = i1[4:0];
				imm = i1[21:10];
				ws = i2[20:16];
				if (is_stx(i2, sz, xn) && i2[4:0] == ws2 && is_cbnz(i3, ws, 19'h7FFFD)) begin
					hit = 1'b1;
					p.cons = 5'd16;
					p.wrd[0] = 32'hD2800000 | {15'd0, imm, ws};
					p.wrd[1] = 32'hB8E00000 | szb | {11'd0, ws, 6'd0, xn, wt};
					p.mem[1] = 1'b1;
					p.wrd[2] = i1;
					p.cnt = 3'd3;
					if (ws != 5'd31) begin
						p.wrd[3] = 32'h2A1F03E0 | {27'd0, ws};
						p.cnt = 3'd4;
					end
				end
			end
			// compare and swap
			if (!hit && (i1 & 32'hFFE0FC1F) == (d64 ? 32'hEB00001F : 32'h6B00001F) &&
					i1[9:5] == wt) begin
				wexp = i1[20:16];
				ws = i3[20:16];
				wnew = i3[4:0];
				if ((i2 & 32'hFF00001F) == 32'h54000001 && i2[23:5] == 19'd3 &&
						is_stx(i3, sz, xn) && is_cbnz(i4, ws, 19'h7FFFC) && wt != wexp) begin
					p.cons = 5'd20;
					p.wrd[0] = 32'h2A000000 | szd | {11'd0, wexp, 6'd0, 5'd31, wt};
					p.wrd[1] = (d64 ? 32'hC8E0FC00 : 32'h88E0FC00) |
						{11'd0, wt, 6'd0, xn, wnew};
					p.mem[1] = 1'b1;
					p.wrd[2] = 32'h6B00001F | szd | {11'd0, wexp, 6'd0, wt, 5'd0};
					p.cnt = 3'd3;
					if (ws != 5'd31) begin
						p.wrd[3] = 32'h9A800000 | {11'd0, ws, 6'd0, 5'd31, ws};
						p.cnt = 3'd4;
					end
				end
			end
		end
		if (p.cnt == 3'd0) p = '0;
		return p;
	endfunction

endpackage

/* rtl/eltlr_if.sv */
// Valid/ready channel interfaces for windows and results.
interface eltlr_win_if;
	import eltlr_pkg::*;
	logic    valid;
	logic    ready;
	window_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface eltlr_res_if;
	import eltlr_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/eltlr_front.sv */
// Front end: accepts a window, classifies it into a plan and registers it.
module eltlr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	eltlr_win_if.sink            win,
	input  eltlr_pkg::cfg_t      cfg,
	output logic                 plan_valid_s1,
	output eltlr_pkg::plan_t     plan_s1,
	input  logic                 plan_ready
);
	import eltlr_pkg::*;

	assign win.ready = !plan_valid_s1 || plan_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_valid_s1 <= 1'b0;
		end else if (win.ready) begin
			plan_valid_s1 <= win.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win.valid && win.ready) begin
			plan_s1 <= classify(win.data, cfg);
		end
	end
endmodule

/* rtl/eltlr_queue.sv */
// Two-entry plan queue between front and back ends.
module eltlr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  eltlr_pkg::plan_t in_plan,
	output logic             in_ready,
	output logic             out_valid,
	output eltlr_pkg::plan_t out_plan,
	input  logic             out_ready
);
	import eltlr_pkg::*;

	plan_t     mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_plan  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_plan;
	end
endmodule

/* rtl/eltlr_back.sv */
// Back end: one result per plan word; an empty plan gives one miss result.
module eltlr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             plan_valid,
	input  eltlr_pkg::plan_t plan,
	output logic             plan_ready,
	eltlr_res_if.source      res
);
	import eltlr_pkg::*;

	logic [1:0] idx_q;
	logic       last, load;
	result_t    cur;

	assign last = plan.cnt == 3'd0 || {1'b0, idx_q} == plan.cnt - 3'd1;
	assign load = !res.valid || res.ready;
	assign plan_ready = plan_valid && load && last;

	always_comb begin
		cur = '0;
		cur.last_of_run = last;
		if (plan.cnt != 3'd0) begin
			cur.replacement_word = plan.wrd[idx_q];
			cur.word_valid       = 1'b1;
			cur.touches_memory   = plan.mem[idx_q];
			cur.bytes_consumed   = plan.cons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
			idx_q     <= 2'd0;
		end else if (load) begin
			res.valid <= plan_valid;
			if (plan_valid) idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && plan_valid) res.data <= cur;
	end
endmodule

/* rtl/exclusive_loop_to_lse_rewriter_core.sv */
// Top level of the exclusive-loop to LSE rewriter.
// Path: a window passes through the front-end plan register, the plan queue and the back-end result register.
// Throughput: one result per cycle while the result channel is not stalled; a window emits 1 to 4 results,
// set by the number of words in its plan, through the single result register in the back end.
// Reset clears all valid flags and both configuration registers (arst_n, async).
module exclusive_loop_to_lse_rewriter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	eltlr_win_if.sink                     win,
	eltlr_res_if.source                   res,
	input  logic                          cfg_we,
	input  logic [eltlr_pkg::IdxW-1:0]    cfg_index,
	input  logic [eltlr_pkg::WordW-1:0]   cfg_data
);
	import eltlr_pkg::*;

	cfg_t  cfg_q;
	logic  fv_s1, f_rdy, qv, q_rdy;
	plan_t fp_s1, qp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegBaseBias: cfg_q.base_bias <= cfg_data[0];
				RegStolen:   cfg_q.stolen    <= cfg_data;
				default: ;
			endcase
		end
	end

	eltlr_front u_front (.clk, .arst_n, .win, .cfg(cfg_q), .plan_valid_s1(fv_s1),
		.plan_s1(fp_s1), .plan_ready(f_rdy));

	eltlr_queue u_queue (.clk, .arst_n, .in_valid(fv_s1), .in_plan(fp_s1), .in_ready(f_rdy),
		.out_valid(qv), .out_plan(qp), .out_ready(q_rdy));

	eltlr_back u_back (.clk, .arst_n, .plan_valid(qv), .plan(qp), .plan_ready(q_rdy), .res);

	a_last_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.data.word_valid |-> res.data.last_of_run &&
		res.data.bytes_consumed == 5'd0)
		else $error("miss result malformed");

	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rdy |-> qv)
		else $error("queue popped while empty");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result changed while stalled");
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the exclusive-loop to LSE rewriter: windows in, checked words out.
module testbench;
	import eltlr_pkg::*;

	localparam int KSwap = 0, KRegOp = 1, KAddImm = 2, KCas = 3, KNoise = 4;
	localparam int OpAdd = 0, OpOrr = 1, OpEor = 2, OpAnd = 3, OpSub = 4;
	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IdxW-1:0] cfg_index;
	logic [WordW-1:0] cfg_data;

	eltlr_win_if win_ch ();
	eltlr_res_if res_ch ();

	exclusive_loop_to_lse_rewriter_core dut (
		.clk(clk), .arst_n(arst_n), .win(win_ch), .res(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// mirror of the configuration
	logic bias_on;
	logic [31:0] stolen_mask;

	window_t window_q[$];
	result_t rewrite_q[$];
	int windows_sent, words_seen, windows_rewritten, fail_count, cycles;
	bit calm_send, calm_recv;

	word_t staged_word[4];
	logic staged_mem[4];
	int staged_cnt;

	function automatic void stage(input word_t w, input logic m);
		staged_word[staged_cnt] = w;
		staged_mem[staged_cnt] = m;
		staged_cnt++;
	endfunction

	function automatic bit is_store_excl(input word_t w, input logic [1:0] sz,
			input logic [4:0] xn);
		return (w & 32'h3F400000) == 32'h08000000 && w[31:30] == sz &&
			w[14:10] == 5'd31 && w[9:5] == xn;
	endfunction

	function automatic bit is_retry_branch(input word_t w, input logic [4:0] ws,
			input logic [18:0] off);
		return w[31:24] == 8'h35 && w[4:0] == ws && w[23:5] == off;
	endfunction

	function automatic void status_clear(input logic [4:0] ws);
		if (ws != 5'd31) stage(32'h2A1F03E0 | ws, 1'b0);
	endfunction

	function automatic void predict_rewrite(input window_t win);
		word_t i0, i1, i2, i3, i4, szb, szd, lse;
		logic [1:0] sz;
		logic [4:0] wt, xn, ws, wv, ws2, n, m, wexp, wnew;
		int wm, op, cons;
		bit done;
		result_t r;
		word_t base32[5], base64[5];
		base32 = '{32'h0B000000, 32'h2A000000, 32'h4A000000, 32'h0A000000, 32'h4B000000};
		base64 = '{32'h8B000000, 32'hAA000000, 32'hCA000000, 32'h8A000000, 32'hCB000000};
		staged_cnt = 0;
		cons = 0;
		done = 0;
		i0 = win.words[0]; i1 = win.words[1]; i2 = win.words[2];
		i3 = win.words[3]; i4 = win.words[4];
		sz = i0[31:30];
		wt = i0[4:0];
		xn = i0[9:5];
		szb = sz == 2'd3 ? 32'h40000000 : 32'h0;
		szd = sz == 2'd3 ? 32'h80000000 : 32'h0;
		if ((i0 & 32'h3F400000) == 32'h08400000 && sz[1] && i0[20:16] == 5'd31 &&
				i0[14:10] == 5'd31) begin
			ws = i1[20:16];
			wv = i1[4:0];
			if (is_store_excl(i1, sz, xn) && is_retry_branch(i2, ws, 19'h7FFFE) &&
					(bias_on || stolen_mask[wt] || stolen_mask[xn] || stolen_mask[ws] ||
					stolen_mask[wv])) begin
				stage(32'hB8E08000 | szb | (wv << 16) | (xn << 5) | wt, 1'b1);
				status_clear(ws);
				cons = 12;
				done = 1;
			end
			if (!done) begin
				op = -1;
				for (int k = 0; k < 5; k++)
					if (op < 0 && (i1 & 32'hFFE0FC00) == (sz == 2'd3 ? base64[k] : base32[k]))
						op = k;
				if (op >= 0) begin
					ws2 = i1[4:0]; n = i1[9:5]; m = i1[20:16];
					wm = 32;
					if (n == wt) wm = m;
					else if (op != OpSub && m == wt) wm = n;
					ws = i2[20:16];
					if (wm < 32 && is_store_excl(i2, sz, xn) && i2[4:0] == ws2 &&
							is_retry_branch(i3, ws, 19'h7FFFD)) begin
						done = 1;
						if (!(op >= OpAnd && wm == ws)) begin
							if (op <= OpEor) begin
								lse = op == OpAdd ? 32'hB8E00000 :
									op == OpOrr ? 32'hB8E03000 : 32'hB8E02000;
								stage(lse | szb | (wm << 16) | (xn << 5) | wt, 1'b1);
							end else if (op == OpAnd) begin
								stage(32'h2A200000 | szd | (wm << 16) | (31 << 5) | ws, 1'b0);
								stage(32'hB8E01000 | szb | (ws << 16) | (xn << 5) | wt, 1'b1);
							end else begin
								stage(32'h4B000000 | szd | (wm << 16) | (31 << 5) | ws, 1'b0);
								stage(32'hB8E00000 | szb | (ws << 16) | (xn << 5) | wt, 1'b1);
							end
							stage(i1, 1'b0);
							status_clear(ws);
							cons = 16;
						end
					end
				end
			end
			if (!done && (i1 & 32'hFFC00000) == (sz == 2'd3 ? 32'h91000000 : 32'h11000000) &&
					i1[9:5] == wt) begin
				ws = i2[20:16];
				if (is_store_excl(i2, sz, xn) && i2[4:0] == i1[4:0] &&
						is_retry_branch(i3, ws, 19'h7FFFD)) begin
					stage(32'hD2800000 | (i1[21:10] << 5) | ws, 1'b0);
					stage(32'hB8E00000 | szb | (ws << 16) | (xn << 5) | wt, 1'b1);
					stage(i1, 1'b0);
					status_clear(ws);
					cons = 16;
					done = 1;
				end
			end
			if (!done && (i1 & 32'hFFE0FC1F) == (sz == 2'd3 ? 32'hEB00001F : 32'h6B00001F) &&
					i1[9:5] == wt) begin
				wexp = i1[20:16];
				ws = i3[20:16];
				wnew = i3[4:0];
				if ((i2 & 32'hFF00001F) == 32'h54000001 && i2[23:5] == 19'd3 &&
						is_store_excl(i3, sz, xn) && is_retry_branch(i4, ws, 19'h7FFFC) &&
						wt != wexp) begin
					stage(32'h2A000000 | szd | (wexp << 16) | (31 << 5) | wt, 1'b0);
					stage((sz == 2'd3 ? 32'hC8E0FC00 : 32'h88E0FC00) | (wt << 16) |
						(xn << 5) | wnew, 1'b1);
					stage(32'h6B00001F | szd | (wexp << 16) | (wt << 5), 1'b0);
					if (ws != 5'd31) stage(32'h9A800000 | (ws << 16) | (31 << 5) | ws, 1'b0);
					cons = 20;
				end
			end
		end
		if (cons == 0 || staged_cnt == 0) begin
			r = '0;
			r.last_of_run = 1'b1;
			rewrite_q.push_back(r);
		end else begin
			windows_rewritten++;
			for (int k = 0; k < staged_cnt; k++) begin
				r.replacement_word = staged_word[k];
				r.word_valid = 1'b1;
				r.touches_memory = staged_mem[k];
				r.bytes_consumed = cons[ConsW-1:0];
				r.last_of_run = (k == staged_cnt - 1);
				rewrite_q.push_back(r);
			end
		end
	endfunction

	// Build a retry loop of the given shape; unused words are random filler.
	function automatic window_t build_loop(input int kind, input bit d64, input int op,
			input logic [4:0] wt, input logic [4:0] xn, input logic [4:0] ws,
			input logic [4:0] wv, input logic [4:0] wd, input logic [11:0] imm,
			input bit swap_ops);
		window_t w;
		word_t sz, free_bits, base;
		word_t b32[5], b64[5];
		b32 = '{32'h0B000000, 32'h2A000000, 32'h4A000000, 32'h0A000000, 32'h4B000000};
		b64 = '{32'h8B000000, 32'hAA000000, 32'hCA000000, 32'h8A000000, 32'hCB000000};
		for (int k = 0; k < NWords; k++) w.words[k] = $urandom;
		sz = d64 ? 32'hC0000000 : 32'h80000000;
		free_bits = $urandom & 32'h00A08000;
		w.words[0] = 32'h08400000 | sz | free_bits | (31 << 16) | (31 << 10) | (xn << 5) | wt;
		free_bits = $urandom & 32'h00A08000;
		case (kind)
			KSwap: begin
				w.words[1] = 32'h08000000 | sz | free_bits | (ws << 16) | (31 << 10) |
					(xn << 5) | wv;
				w.words[2] = 32'h35000000 | (32'h7FFFE << 5) | ws;
			end
			KRegOp, KAddImm: begin
				if (kind == KRegOp) begin
					base = d64 ? b64[op] : b32[op];
					w.words[1] = swap_ops ? base | (wt << 16) | (wv << 5) | wd :
						base | (wv << 16) | (wt << 5) | wd;
				end else
					w.words[1] = (d64 ? 32'h91000000 : 32'h11000000) | (imm << 10) |
						(wt << 5) | wd;
				w.words[2] = 32'h08000000 | sz | free_bits | (ws << 16) | (31 << 10) |
					(xn << 5) | wd;
				w.words[3] = 32'h35000000 | (32'h7FFFD << 5) | ws;
			end
			KCas: begin
				w.words[1] = (d64 ? 32'hEB00001F : 32'h6B00001F) | (wv << 16) | (wt << 5);
				w.words[2] = 32'h54000001 | (3 << 5);
				w.words[3] = 32'h08000000 | sz | free_bits | (ws << 16) | (31 << 10) |
					(xn << 5) | wd;
				w.words[4] = 32'h35000000 | (32'h7FFFC << 5) | ws;
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [4:0] pick_reg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 5'($urandom_range(0, 3));
		if (r < 65) return 5'd31;
		return 5'($urandom);
	endfunction

	function automatic window_t random_window();
		window_t w;
		int kind, bit_pos;
		kind = $urandom_range(0, 9);
		if (kind >= KNoise) begin
			if (kind == 9) kind = KNoise;
			else kind = $urandom_range(KSwap, KCas);
		end
		if (kind == KNoise) begin
			for (int k = 0; k < NWords; k++) w.words[k] = $urandom;
			return w;
		end
		w = build_loop(kind, 1'($urandom_range(0, 1)), $urandom_range(OpAdd, OpSub),
			pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(), 12'($urandom),
			1'($urandom_range(0, 1)));
		if ($urandom_range(0, 99) < 15) begin
			bit_pos = $urandom_range(0, NWords * WordW - 1);
			w[bit_pos] = ~w[bit_pos];
		end
		return w;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// window driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ch.valid <= 1'b0;
			win_ch.data <= '0;
			send_gap <= 0;
		end else begin
			if (win_ch.valid && win_ch.ready) begin
				predict_rewrite(win_ch.data);
				windows_sent++;
			end
			if (win_ch.valid && !win_ch.ready) begin
			end else if (send_gap > 0) begin
				win_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (window_q.size() > 0) begin
				win_ch.valid <= 1'b1;
				win_ch.data <= window_q.pop_front();
				send_gap <= pick_gap(calm_send);
			end else
				win_ch.valid <= 1'b0;
		end
	end

	// result monitor
	int recv_gap;
	result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				words_seen++;
				if (rewrite_q.size() == 0) begin
					$error("unexpected transaction: word %h", res_ch.data.replacement_word);
					fail_count++;
				end else begin
					want = rewrite_q.pop_front();
					if (res_ch.data.replacement_word !== want.replacement_word) begin
						$error("replacement_word: expected %h, got %h",
							want.replacement_word, res_ch.data.replacement_word);
						fail_count++;
					end
					if (res_ch.data.word_valid !== want.word_valid) begin
						$error("word_valid: expected %b, got %b",
							want.word_valid, res_ch.data.word_valid);
						fail_count++;
					end
					if (res_ch.data.touches_memory !== want.touches_memory) begin
						$error("touches_memory: expected %b, got %b",
							want.touches_memory, res_ch.data.touches_memory);
						fail_count++;
					end
					if (res_ch.data.bytes_consumed !== want.bytes_consumed) begin
						$error("bytes_consumed: expected %0d, got %0d",
							want.bytes_consumed, res_ch.data.bytes_consumed);
						fail_count++;
					end
					if (res_ch.data.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b",
							want.last_of_run, res_ch.data.last_of_run);
						fail_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				res_ch.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				res_ch.ready <= 1'b1;
				recv_gap <= pick_gap(calm_recv);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegBaseBias) bias_on = val[0];
		else stolen_mask = val;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (window_q.size() > 0 || win_ch.valid || rewrite_q.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	logic [31:0] bias_set[5];
	logic [31:0] mask_set[5];

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bias_on = 1'b0;
		stolen_mask = '0;
		calm_send = 0;
		calm_recv = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		window_q.push_back('0);
		window_q.push_back('1);
		// swap loop with no bias and nothing stolen stays a miss
		window_q.push_back(build_loop(KSwap, 1, 0, 1, 2, 3, 4, 5, 0, 0));
		for (int op = OpAdd; op <= OpSub; op++) begin
			window_q.push_back(build_loop(KRegOp, 0, op, 1, 2, 3, 4, 5, 0, 0));
			window_q.push_back(build_loop(KRegOp, 1, op, 6, 7, 31, 8, 9, 0, op != OpSub));
		end
		// and/sub with the status register equal to the operand
		window_q.push_back(build_loop(KRegOp, 0, OpAnd, 1, 2, 4, 4, 5, 0, 0));
		window_q.push_back(build_loop(KRegOp, 1, OpSub, 1, 2, 4, 4, 5, 0, 0));
		window_q.push_back(build_loop(KAddImm, 0, 0, 1, 2, 3, 0, 5, 12'hFFF, 0));
		window_q.push_back(build_loop(KAddImm, 1, 0, 31, 31, 31, 0, 31, 12'h000, 0));
		window_q.push_back(build_loop(KCas, 0, 0, 1, 2, 3, 4, 5, 0, 0));
		window_q.push_back(build_loop(KCas, 1, 0, 1, 2, 31, 4, 5, 0, 0));
		// compare value equal to the target register
		window_q.push_back(build_loop(KCas, 1, 0, 4, 2, 3, 4, 5, 0, 0));
		drain();

		bias_set = '{0, 1, 0, 1, 0};
		mask_set = '{32'h0, 32'h0, 32'hFFFFFFFF, $urandom, 32'h80000001};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(RegBaseBias, bias_set[ph]);
			write_reg(RegStolen, mask_set[ph]);
			calm_send = (ph == 1);
			calm_recv = (ph == 3);
			for (int k = 0; k < 58; k++) window_q.push_back(random_window());
			drain();
		end

		$display("%0d windows sent, %0d rewritten, %0d result words checked",
			windows_sent, windows_rewritten, words_seen);
		$display("covered all loop shapes in both sizes, bias on and off, several masks");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
